// ----- hdl/ptt_pkg.sv -----
// Shared constants and types for the pan target tracker.
`default_nettype none
package ptt_pkg;

	localparam int ANGLE_W    = 16;
	localparam int LIMIT_W    = 15;
	localparam int GAIN_W     = 16;
	localparam int TIME_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_AZIMUTH_GAIN     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PAN_RATE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AZIMUTH_DEADBAND = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEAD_WINDOW      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SOFT_ANGLE_LIMIT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_MODE    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT_DIRECTION = 3'd6;

	localparam logic signed [ANGLE_W-1:0] UNIT_DIR  = 16'sd4096;
	localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 16'sd32767;
	localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = -16'sd32768;

	typedef struct packed {
		logic [GAIN_W-1:0]  azimuth_gain;
		logic [GAIN_W-1:0]  max_pan_rate;
		logic [LIMIT_W-1:0] azimuth_deadband;
		logic [LIMIT_W-1:0] lead_window;
		logic [LIMIT_W-1:0] soft_angle_limit;
		logic               velocity_mode;
		logic               invert_direction;
	} cfg_t;

endpackage
`default_nettype wire

// ----- hdl/pan_target_tracker.sv -----
// Pan target tracker: input register, one-pass target update, result register.
// An accepted word passes from the input register to the result register, which drives out_valid.
// Throughput: one word per cycle while the output is not stalled; held_target is updated as each word advances.
// in_stall rises only while both stages hold words and the output is stalled.
// Reset clears the valid flags and held_target and loads register defaults.
`default_nettype none
module pan_target_tracker (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cfg_write,
	input  wire  [ptt_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire  [ptt_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire                                   command,
	input  wire                                   owner_seen,
	input  wire  signed [ptt_pkg::ANGLE_W-1:0]    owner_azimuth,
	input  wire  [ptt_pkg::LIMIT_W-1:0]           near_deadzone,
	input  wire  signed [ptt_pkg::ANGLE_W-1:0]    stage_angle,
	input  wire  [ptt_pkg::TIME_W-1:0]            step_time,
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output logic signed [ptt_pkg::ANGLE_W-1:0]    pan_target,
	output logic                                  pan_active
);
	import ptt_pkg::*;

	cfg_t cfg_q;

	logic                      valid_s1;
	logic                      command_s1;
	logic                      seen_s1;
	logic signed [ANGLE_W-1:0] az_s1;
	logic [LIMIT_W-1:0]        near_dz_s1;
	logic signed [ANGLE_W-1:0] stage_s1;
	logic [TIME_W-1:0]         dt_s1;

	logic                      valid_s2;
	logic signed [ANGLE_W-1:0] target_s2;
	logic                      active_s2;

	logic signed [ANGLE_W-1:0] held_target_q;

	logic out_free, advance, load_s1;

	logic [ANGLE_W:0]            abs_az;
	logic signed [32:0]          prod;
	logic signed [33:0]          rounded;
	logic signed [21:0]          delta;
	logic [31:0]                 rate_prod;
	logic signed [21:0]          step_cap;
	logic signed [16:0]          delta_c;
	logic signed [17:0]          sum;
	logic signed [ANGLE_W-1:0]   t_sat;
	logic signed [16:0]          soft_lim;
	logic signed [ANGLE_W-1:0]   t_soft;
	logic signed [17:0]          lo_raw, hi_raw;
	logic signed [ANGLE_W-1:0]   lo_b, hi_b;
	logic signed [ANGLE_W-1:0]   t_lead;
	logic signed [ANGLE_W-1:0]   dir;
	logic                        do_move;
	logic signed [ANGLE_W-1:0]   next_held;
	logic signed [ANGLE_W-1:0]   res_target;
	logic                        res_active;

	assign out_free = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.azimuth_gain     <= 16'd4096;
			cfg_q.max_pan_rate     <= 16'd4096;
			cfg_q.azimuth_deadband <= 15'd205;
			cfg_q.lead_window      <= 15'd0;
			cfg_q.soft_angle_limit <= 15'd12868;
			cfg_q.velocity_mode    <= 1'b0;
			cfg_q.invert_direction <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_AZIMUTH_GAIN:     cfg_q.azimuth_gain     <= cfg_data;
				REG_MAX_PAN_RATE:     cfg_q.max_pan_rate     <= cfg_data;
				REG_AZIMUTH_DEADBAND: cfg_q.azimuth_deadband <= cfg_data[LIMIT_W-1:0];
				REG_LEAD_WINDOW:      cfg_q.lead_window      <= cfg_data[LIMIT_W-1:0];
				REG_SOFT_ANGLE_LIMIT: cfg_q.soft_angle_limit <= cfg_data[LIMIT_W-1:0];
				REG_VELOCITY_MODE:    cfg_q.velocity_mode    <= cfg_data[0];
				REG_INVERT_DIRECTION: cfg_q.invert_direction <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			command_s1 <= command;
			seen_s1    <= owner_seen;
			az_s1      <= owner_azimuth;
			near_dz_s1 <= near_deadzone;
			stage_s1   <= stage_angle;
			dt_s1      <= step_time;
		end
	end

	always_comb begin
		abs_az = az_s1[ANGLE_W-1] ? 17'(-{az_s1[ANGLE_W-1], az_s1}) : {1'b0, az_s1};

		prod     = $signed({1'b0, cfg_q.azimuth_gain}) * az_s1;
		rounded  = -{prod[32], prod} + 34'sd2048;
		delta    = rounded[33:12];

		rate_prod = cfg_q.max_pan_rate * dt_s1;
		step_cap  = $signed({6'd0, rate_prod[31:16]});

		if (delta < -step_cap) begin
			delta_c = 17'(-step_cap);
		end else if (delta > step_cap) begin
			delta_c = step_cap[16:0];
		end else begin
			delta_c = delta[16:0];
		end

		sum = {{2{held_target_q[ANGLE_W-1]}}, held_target_q} + {delta_c[16], delta_c};
		if (sum < 18'sd0 - 18'sd32768) begin
			t_sat = ANGLE_MIN;
		end else if (sum > 18'sd32767) begin
			t_sat = ANGLE_MAX;
		end else begin
			t_sat = sum[ANGLE_W-1:0];
		end

		soft_lim = $signed({2'b00, cfg_q.soft_angle_limit});
		if ($signed({t_sat[ANGLE_W-1], t_sat}) < -soft_lim) begin
			t_soft = 16'(-soft_lim);
		end else if ($signed({t_sat[ANGLE_W-1], t_sat}) > soft_lim) begin
			t_soft = soft_lim[ANGLE_W-1:0];
		end else begin
			t_soft = t_sat;
		end

		lo_raw = {{2{stage_s1[ANGLE_W-1]}}, stage_s1} - $signed({3'b000, cfg_q.lead_window});
		hi_raw = {{2{stage_s1[ANGLE_W-1]}}, stage_s1} + $signed({3'b000, cfg_q.lead_window});
		lo_b   = (lo_raw < 18'sd0 - 18'sd32768) ? ANGLE_MIN : lo_raw[ANGLE_W-1:0];
		hi_b   = (hi_raw > 18'sd32767) ? ANGLE_MAX : hi_raw[ANGLE_W-1:0];
		if (cfg_q.lead_window == '0) begin
			t_lead = t_soft;
		end else if (t_soft < lo_b) begin
			t_lead = lo_b;
		end else if (t_soft > hi_b) begin
			t_lead = hi_b;
		end else begin
			t_lead = t_soft;
		end

		dir = '0;
		if (seen_s1 && (abs_az > {2'b00, near_dz_s1})) begin
			dir = (az_s1[ANGLE_W-1] ^ cfg_q.invert_direction) ? UNIT_DIR : -UNIT_DIR;
		end

		do_move = seen_s1 && (abs_az > {2'b00, cfg_q.azimuth_deadband});

		next_held  = held_target_q;
		res_target = held_target_q;
		res_active = 1'b1;
		if (command_s1) begin
			next_held  = stage_s1;
			res_target = stage_s1;
			res_active = 1'b0;
		end else if (cfg_q.velocity_mode) begin
			res_target = dir;
			res_active = seen_s1;
		end else if (do_move) begin
			next_held  = t_lead;
			res_target = t_lead;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_target_q <= '0;
			valid_s2      <= 1'b0;
		end else begin
			if (advance) begin
				held_target_q <= next_held;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			target_s2 <= res_target;
			active_s2 <= res_active;
		end
	end

	assign out_valid  = valid_s2;
	assign pan_target = target_s2;
	assign pan_active = active_s2;

endmodule
`default_nettype wire

// ----- hdl/ptt_checker.sv -----
// Port-level checks for the pan target tracker, bound to the top level.
`default_nettype none
module ptt_checker (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                in_valid,
	input wire                                in_stall,
	input wire                                out_valid,
	input wire                                out_stall,
	input wire signed [ptt_pkg::ANGLE_W-1:0]  pan_target,
	input wire                                pan_active
);
	import ptt_pkg::*;

	// input side backs up only behind a stalled output word
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall without a stalled output word");

	// an accepted word is followed by out_valid once it has passed the input register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> ##1 out_valid)
		else $error("accepted word did not reach the output");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
			(out_valid && $stable(pan_target) && $stable(pan_active)))
		else $error("stalled output word changed");

endmodule

bind pan_target_tracker ptt_checker u_ptt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.pan_target (pan_target),
	.pan_active (pan_active)
);
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for pan_target_tracker: random and directed words, scoreboard.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ptt_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 4;

	typedef struct packed {
		logic                      command;
		logic                      owner_seen;
		logic signed [ANGLE_W-1:0] owner_azimuth;
		logic [LIMIT_W-1:0]        near_deadzone;
		logic signed [ANGLE_W-1:0] stage_angle;
		logic [TIME_W-1:0]         step_time;
	} track_word_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] pan_target;
		logic                      pan_active;
	} pan_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	track_word_t           drv_word = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic signed [ANGLE_W-1:0] pan_target;
	logic                  pan_active;

	track_word_t tracker_words[$];
	pan_result_t pending_targets[$];

	cfg_t                      model_cfg;
	logic signed [ANGLE_W-1:0] held_tgt;
	logic                      calm = 1'b0;

	int err_count = 0;
	int words_in = 0;
	int results_seen = 0;
	int engage_count = 0;
	int move_count = 0;
	int velocity_count = 0;
	int settings_count = 0;
	int idle_cycles = 0;

	pan_result_t got_res;
	pan_result_t want_res;

	pan_target_tracker dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (drv_word.command),
		.owner_seen    (drv_word.owner_seen),
		.owner_azimuth (drv_word.owner_azimuth),
		.near_deadzone (drv_word.near_deadzone),
		.stage_angle   (drv_word.stage_angle),
		.step_time     (drv_word.step_time),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pan_target    (pan_target),
		.pan_active    (pan_active)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint bound(longint v, longint lo, longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Updates held_tgt and returns the result the tracker owes for this word.
	function automatic pan_result_t track_target(track_word_t w);
		longint az, abs_az, stage, corr, step_lim, t, lo, hi, lead;
		logic signed [ANGLE_W-1:0] dir;
		pan_result_t r;
		az = w.owner_azimuth;
		stage = w.stage_angle;
		abs_az = (az < 0) ? -az : az;
		lead = longint'(model_cfg.lead_window);
		if (w.command) begin
			engage_count++;
			held_tgt = w.stage_angle;
			r.pan_target = w.stage_angle;
			r.pan_active = 1'b0;
		end else if (model_cfg.velocity_mode) begin
			velocity_count++;
			dir = '0;
			if (w.owner_seen && abs_az > longint'(w.near_deadzone)) begin
				dir = (az >= 0) ? -UNIT_DIR : UNIT_DIR;
				if (model_cfg.invert_direction)
					dir = -dir;
			end
			r.pan_target = dir;
			r.pan_active = w.owner_seen;
		end else begin
			if (w.owner_seen && abs_az > longint'(model_cfg.azimuth_deadband)) begin
				move_count++;
				// Q7.24 product rounded to Q3.12, floor division by shift
				corr = (-(longint'(model_cfg.azimuth_gain) * az) + 2048) >>> 12;
				step_lim = (longint'(model_cfg.max_pan_rate) * longint'(w.step_time)) >>> 16;
				corr = bound(corr, -step_lim, step_lim);
				t = bound(longint'(held_tgt) + corr, -32768, 32767);
				t = bound(t, -longint'(model_cfg.soft_angle_limit),
					longint'(model_cfg.soft_angle_limit));
				if (lead != 0) begin
					lo = bound(stage - lead, -32768, 32767);
					hi = bound(stage + lead, -32768, 32767);
					t = bound(t, lo, hi);
				end
				held_tgt = t[ANGLE_W-1:0];
			end
			r.pan_target = held_tgt;
			r.pan_active = 1'b1;
		end
		return r;
	endfunction

	function automatic int pick_value(int top);
		case ($urandom_range(3))
			0: return 0;
			1: return top;
			2: return $urandom_range(1, 1000);
			default: return $urandom_range(top);
		endcase
	endfunction

	function automatic track_word_t rand_word();
		track_word_t w;
		int v;
		w.command = ($urandom_range(99) < 8);
		w.owner_seen = ($urandom_range(99) < 80);
		case ($urandom_range(3))
			0: v = $urandom_range(65535);
			1: v = int'($urandom_range(1200)) - 600;
			2: begin
				v = int'(model_cfg.velocity_mode ? 0 : model_cfg.azimuth_deadband)
					+ int'($urandom_range(4)) - 2;
				if ($urandom_range(1))
					v = -v;
			end
			default: case ($urandom_range(4))
				0: v = -32768;
				1: v = 32767;
				2: v = 0;
				3: v = -1;
				default: v = 1;
			endcase
		endcase
		w.owner_azimuth = v[ANGLE_W-1:0];
		w.near_deadzone = $urandom_range(1) ? LIMIT_W'($urandom_range(32767))
			: LIMIT_W'($urandom_range(700));
		case ($urandom_range(6))
			0: w.stage_angle = $urandom_range(1) ? ANGLE_MAX : ANGLE_MIN;
			1: w.stage_angle = held_tgt + $signed(16'(int'($urandom_range(400)) - 200));
			default: w.stage_angle = ANGLE_W'($urandom_range(65535));
		endcase
		case ($urandom_range(9))
			0: w.step_time = '0;
			1: w.step_time = '1;
			default: w.step_time = TIME_W'($urandom_range(65535));
		endcase
		return w;
	endfunction

	task automatic flag(input string msg);
		err_count++;
		if (err_count <= 10)
			$display("%s", msg);
	endtask

	// Sender: holds a stalled word, otherwise offers the next one or idles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				words_in++;
				pending_targets.push_back(track_target(drv_word));
			end
			if (!in_valid || !in_stall) begin
				if (tracker_words.size() != 0 && (calm || $urandom_range(99) >= 24)) begin
					drv_word <= tracker_words.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stall, compares each word against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < 24);
			if (out_valid && !out_stall) begin
				results_seen++;
				got_res.pan_target = pan_target;
				got_res.pan_active = pan_active;
				if (pending_targets.size() == 0) begin
					flag($sformatf("unexpected word: pan_target %0d pan_active %0d",
						got_res.pan_target, got_res.pan_active));
				end else begin
					want_res = pending_targets.pop_front();
					if (got_res.pan_target !== want_res.pan_target)
						flag($sformatf("result %0d pan_target: expected %0d got %0d",
							results_seen, want_res.pan_target, got_res.pan_target));
					if (got_res.pan_active !== want_res.pan_active)
						flag($sformatf("result %0d pan_active: expected %0d got %0d",
							results_seen, want_res.pan_active, got_res.pan_active));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", idle_cycles);
				$display("status: fail");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic drain();
		do
			@(posedge clk);
		while (tracker_words.size() != 0 || in_valid || pending_targets.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		case (idx)
			REG_AZIMUTH_GAIN:     model_cfg.azimuth_gain = val[GAIN_W-1:0];
			REG_MAX_PAN_RATE:     model_cfg.max_pan_rate = val[GAIN_W-1:0];
			REG_AZIMUTH_DEADBAND: model_cfg.azimuth_deadband = val[LIMIT_W-1:0];
			REG_LEAD_WINDOW:      model_cfg.lead_window = val[LIMIT_W-1:0];
			REG_SOFT_ANGLE_LIMIT: model_cfg.soft_angle_limit = val[LIMIT_W-1:0];
			REG_VELOCITY_MODE:    model_cfg.velocity_mode = val[0];
			REG_INVERT_DIRECTION: model_cfg.invert_direction = val[0];
			default: ;
		endcase
	endtask

	task automatic load_settings(input int gain, input int rate, input int dband,
		input int lead, input int soft_lim, input int vmode, input int inv);
		drain();
		write_reg(REG_AZIMUTH_GAIN, gain);
		write_reg(REG_MAX_PAN_RATE, rate);
		write_reg(REG_AZIMUTH_DEADBAND, dband);
		write_reg(REG_LEAD_WINDOW, lead);
		write_reg(REG_SOFT_ANGLE_LIMIT, soft_lim);
		write_reg(REG_VELOCITY_MODE, vmode);
		write_reg(REG_INVERT_DIRECTION, inv);
		@(posedge clk);
		cfg_write <= 1'b0;
		settings_count++;
	endtask

	task automatic add_word(input logic cmd, input logic seen, input int az, input int nd,
		input int stage, input int dt);
		track_word_t w;
		w.command = cmd;
		w.owner_seen = seen;
		w.owner_azimuth = az[ANGLE_W-1:0];
		w.near_deadzone = nd[LIMIT_W-1:0];
		w.stage_angle = stage[ANGLE_W-1:0];
		w.step_time = dt[TIME_W-1:0];
		tracker_words.push_back(w);
	endtask

	initial begin
		model_cfg.azimuth_gain = 16'd4096;
		model_cfg.max_pan_rate = 16'd4096;
		model_cfg.azimuth_deadband = 15'd205;
		model_cfg.lead_window = '0;
		model_cfg.soft_angle_limit = 15'd12868;
		model_cfg.velocity_mode = 1'b0;
		model_cfg.invert_direction = 1'b0;
		held_tgt = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: deadband edge, saturation at both soft limits, zero step time
		add_word(1, 0, 0, 0, 1000, 0);
		add_word(0, 1, 205, 32767, 0, 65535);
		add_word(0, 1, 206, 0, 0, 65535);
		add_word(0, 1, -206, 0, 0, 65535);
		add_word(0, 0, 20000, 0, 0, 65535);
		add_word(0, 1, -32768, 0, 0, 65535);
		add_word(0, 1, 32767, 0, 0, 0);
		add_word(1, 1, 0, 0, -32768, 0);
		add_word(0, 1, 32767, 0, -32768, 65535);
		add_word(1, 1, 0, 0, 32767, 65535);
		add_word(0, 1, -32768, 0, 32767, 65535);

		load_settings(4096, 4096, 205, 0, 12868, 1, 0);
		add_word(0, 1, 0, 0, 0, 100);
		add_word(0, 1, 1, 0, 0, 100);
		add_word(0, 1, -1, 0, 0, 100);
		add_word(0, 1, -32768, 32767, 0, 100);
		add_word(0, 0, 500, 0, 0, 100);
		add_word(0, 1, 100, 100, 0, 100);
		add_word(1, 1, 900, 0, -5, 100);

		load_settings(4096, 4096, 205, 0, 12868, 1, 1);
		add_word(0, 1, 300, 10, 0, 0);
		add_word(0, 1, -300, 10, 0, 0);

		load_settings(65535, 65535, 0, 32767, 32767, 0, 0);
		add_word(0, 1, 1, 0, 0, 65535);
		add_word(0, 1, -32768, 0, 32767, 65535);
		add_word(0, 1, 32767, 0, -32768, 65535);

		load_settings(0, 0, 32767, 1, 0, 0, 0);
		add_word(0, 1, -32768, 0, 500, 65535);
		add_word(1, 1, 0, 0, 700, 0);

		load_settings(4096, 65535, 20, 1, 32767, 0, 0);
		add_word(0, 1, -32768, 0, 32767, 65535);

		for (int p = 0; p < 10; p++) begin
			if (p == 0)
				load_settings(8192, 2048, 100, 300, 12868, 0, 0);
			else
				load_settings(pick_value(65535), pick_value(65535), pick_value(32767),
					pick_value(32767), pick_value(32767), int'($urandom_range(2) == 0),
					int'($urandom_range(1)));
			calm = (p == 4);
			for (int i = 0; i < 175; i++)
				tracker_words.push_back(rand_word());
			drain();
			calm = 1'b0;
		end

		drain();
		$display("covered %0d words: %0d engage, %0d target moves, %0d velocity mode",
			words_in, engage_count, move_count, velocity_count);
		$display("%0d register settings, %0d results checked, %0d mismatches",
			settings_count, results_seen, err_count);
		if (err_count == 0 && pending_targets.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire
